@@ rtl/core/cmed_pkg.sv @@
// Shared types, sizes and helpers of the closest-match edit distance block.
`default_nettype none

package cmed_pkg;

    // Longest query kept; further query bytes are dropped and flagged.
    localparam int MAX_LEN  = 32;
    // DP column has one cell more than the query.
    localparam int DP_DEPTH = MAX_LEN + 1;
    // Cell index and query length share this width (values 0..MAX_LEN).
    localparam int IDX_W    = $clog2(MAX_LEN + 1);
    // Address width of the query store.
    localparam int QA_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [7:0] DIST_MAX = 8'hFF;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_value;
        logic       has_char;
        logic       first_char;
        logic       last_char;
    } req_t;

    typedef struct packed {
        logic [7:0] distance;
        logic [7:0] candidate_index;
        logic [7:0] best_index;
        logic [7:0] best_distance;
        logic       query_overflow;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             take;      // input beat accepted this cycle
        logic             init_wr;   // write cell_idx with its own index
        logic             cell_wr;   // compute and write cell cell_idx
        logic             rd_en;     // read the column at rd_addr
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] cell_idx;
        logic             fin;       // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [IDX_W-1:0] qlen;
        logic             out_free;
    } status_t;

    // Increment with saturation at DIST_MAX.
    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == DIST_MAX) ? v : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/closest_match_edit_distance.sv @@
// Top level of the closest-match edit distance block: controller plus datapath.
//
// Use: send the query as a string of beats with req_type = 0 (first_char opens
// a new query and clears the candidate count and the best-so-far). Up to
// MAX_LEN bytes are kept; further bytes are dropped and query_overflow is set.
// Then send candidates with req_type = 1, one byte a beat; first_char restarts
// the DP column, has_char = 0 marks an empty candidate. The beat carrying
// last_char produces one result beat: the candidate's distance and index and
// the running best index and distance (ties keep the earlier candidate).
// Steps per beat, with L the stored query length: a query beat is taken at
// once; a candidate byte reads column cell 0 (S_COL0) and then updates cells
// 0..L in S_COLRUN, one column cell per cycle; first_char adds a column reload
// sweep of cells 0..L (S_INIT) before that; last_char adds the final column
// read (S_FINRD) and the result load (S_FINOUT), which waits while a result is held.
// The sweep rate is set by the single write port of the DP column memory, which
// takes one cell a cycle. req_stall is high whenever a beat is in progress.
// Reset makes the column read as zeros, clears the counters and the best index, and sets
// the best distance to 255. If the receiver stalls, hold the result beat; new
// beats are still taken, and a further result waits until the held one leaves.
`default_nettype none

module closest_match_edit_distance (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire cmed_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output cmed_pkg::rsp_t       rsp
);

    cmed_pkg::cmd_t    cmd;
    cmed_pkg::status_t status;

    // Sequencing: beat acceptance, column sweeps and result hand-off.
    cmed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    // Storage and arithmetic: query, DP column, best tracking, result register.
    cmed_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/core/cmed_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cmed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cmed_datapath.sv @@
// Datapath: query store, DP column memory, cell update, best tracking, result register.
`default_nettype none

module cmed_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmed_pkg::req_t    req,
    input  wire cmed_pkg::cmd_t    cmd,
    input  wire logic              rsp_stall,
    output cmed_pkg::status_t      status,
    output logic                   rsp_valid,
    output cmed_pkg::rsp_t         rsp
);

    localparam int IDX_W = cmed_pkg::IDX_W;
    localparam int QA_W  = cmed_pkg::QA_W;

    logic [7:0]       qstore_reg [cmed_pkg::MAX_LEN];
    logic [IDX_W-1:0] qlen_reg, qlen_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       col_reg, col_next;
    logic [7:0]       cand_reg, cand_next;
    logic [7:0]       best_idx_reg, best_idx_next;
    logic [7:0]       best_dist_reg, best_dist_next;
    logic [7:0]       char_reg;
    logic [7:0]       diag_reg;
    logic [7:0]       left_reg;
    logic             cvalid_reg [cmed_pkg::DP_DEPTH];
    logic             rvalid_reg;
    logic             rsp_valid_reg;
    cmed_pkg::rsp_t   rsp_reg;

    logic [IDX_W-1:0] qbase;
    logic             q_store_en;
    logic [7:0]       ram_q;
    logic [7:0]       rd_val;
    logic             we;
    logic [7:0]       wdata;
    logic [7:0]       cell_val;
    logic [7:0]       col_inc;
    logic [IDX_W-1:0] prev_idx;
    logic [7:0]       qchar;
    logic [7:0]       up_inc;
    logic [7:0]       left_inc;
    logic [7:0]       diag_cost;
    logic [7:0]       min_ul;
    logic             beat_q;
    logic             beat_c;

    assign beat_q = cmd.take && !req.req_type;
    assign beat_c = cmd.take && req.req_type;

    // Query bytes: clear on a new query, then append or flag; fin updates best, count.
    always_comb
    begin
        qbase          = req.first_char ? '0 : qlen_reg;
        qlen_next      = qlen_reg;
        ovf_next       = ovf_reg;
        cand_next      = cand_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        q_store_en     = 1'b0;
        if (beat_q)
        begin
            qlen_next = qbase;
            if (req.first_char)
            begin
                ovf_next       = 1'b0;
                cand_next      = '0;
                best_idx_next  = '0;
                best_dist_next = cmed_pkg::DIST_MAX;
            end
            if (req.has_char)
            begin
                if (qbase < IDX_W'(cmed_pkg::MAX_LEN))
                begin
                    q_store_en = 1'b1;
                    qlen_next  = qbase + IDX_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
        else if (cmd.fin)
        begin
            if (rd_val < best_dist_reg)
            begin
                best_dist_next = rd_val;
                best_idx_next  = cand_reg;
            end
            cand_next = cmed_pkg::sat_inc(cand_reg);
        end
    end

    // One DP cell: min of insert, delete and substitute/match.
    always_comb
    begin
        rd_val    = rvalid_reg ? ram_q : 8'd0;
        col_inc   = cmed_pkg::sat_inc(col_reg);
        prev_idx  = cmd.cell_idx - IDX_W'(1);
        qchar     = qstore_reg[prev_idx[QA_W-1:0]];
        up_inc    = cmed_pkg::sat_inc(rd_val);
        left_inc  = cmed_pkg::sat_inc(left_reg);
        diag_cost = (qchar == char_reg) ? diag_reg : cmed_pkg::sat_inc(diag_reg);
        min_ul    = (up_inc < left_inc) ? up_inc : left_inc;
        if (cmd.cell_idx == '0)
        begin
            cell_val = col_inc;
        end
        else
        begin
            cell_val = (diag_cost < min_ul) ? diag_cost : min_ul;
        end
        col_next = col_reg;
        if (beat_c && req.first_char)
        begin
            col_next = '0;
        end
        else if (cmd.cell_wr && cmd.cell_idx == '0)
        begin
            col_next = col_inc;
        end
        we    = cmd.init_wr || cmd.cell_wr;
        wdata = cmd.init_wr ? 8'(cmd.cell_idx) : cell_val;
    end

    cmed_ram #(
        .WIDTH (8),
        .DEPTH (cmed_pkg::DP_DEPTH)
    ) u_column (
        .clk   (clk),
        .we    (we),
        .waddr (cmd.cell_idx),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            col_reg       <= '0;
            cand_reg      <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= cmed_pkg::DIST_MAX;
            rvalid_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < cmed_pkg::DP_DEPTH; i++)
            begin
                cvalid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            qlen_reg      <= qlen_next;
            ovf_reg       <= ovf_next;
            col_reg       <= col_next;
            cand_reg      <= cand_next;
            best_idx_reg  <= best_idx_next;
            best_dist_reg <= best_dist_next;
            if (we)
            begin
                cvalid_reg[cmd.cell_idx] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rvalid_reg <= cvalid_reg[cmd.rd_addr];
            end
            if (cmd.fin)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (q_store_en)
        begin
            qstore_reg[qbase[QA_W-1:0]] <= req.char_value;
        end
        if (beat_c)
        begin
            char_reg <= req.char_value;
        end
        if (cmd.cell_wr)
        begin
            diag_reg <= rd_val;
            left_reg <= cell_val;
        end
        if (cmd.fin)
        begin
            rsp_reg.distance        <= rd_val;
            rsp_reg.candidate_index <= cand_reg;
            rsp_reg.best_index      <= best_idx_next;
            rsp_reg.best_distance   <= best_dist_next;
            rsp_reg.query_overflow  <= ovf_reg;
        end
    end

    assign status.qlen     = qlen_reg;
    assign status.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

`default_nettype wire

@@ rtl/core/cmed_ctrl.sv @@
// Controller: sequences the column sweep, the cell updates and the result load.
`default_nettype none

module cmed_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire cmed_pkg::req_t    req,
    input  wire cmed_pkg::status_t status,
    output logic                   req_stall,
    output cmed_pkg::cmd_t         cmd
);

    localparam int IDX_W = cmed_pkg::IDX_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_COL0   = 3'd2;
    localparam logic [2:0] S_COLRUN = 3'd3;
    localparam logic [2:0] S_FINRD  = 3'd4;
    localparam logic [2:0] S_FINOUT = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             has_reg, has_next;
    logic             last_reg, last_next;
    logic             accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        has_next     = has_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.cell_idx = idx_reg;
        cmd.rd_addr  = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.take = 1'b1;
                    if (req.req_type)
                    begin
                        has_next  = req.has_char;
                        last_next = req.last_char;
                        idx_next  = '0;
                        if (req.first_char)
                        begin
                            state_next = S_INIT;
                        end
                        else if (req.has_char)
                        begin
                            state_next = S_COL0;
                        end
                        else if (req.last_char)
                        begin
                            state_next = S_FINRD;
                        end
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (idx_reg == status.qlen)
                begin
                    idx_next = '0;
                    if (has_reg)
                    begin
                        state_next = S_COL0;
                    end
                    else if (last_reg)
                    begin
                        state_next = S_FINRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_COL0:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_COLRUN;
            end
            S_COLRUN:
            begin
                cmd.cell_wr = 1'b1;
                if (idx_reg != status.qlen)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_reg + IDX_W'(1);
                    idx_next    = idx_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = last_reg ? S_FINRD : S_IDLE;
                end
            end
            S_FINRD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = status.qlen;
                state_next  = S_FINOUT;
            end
            S_FINOUT:
            begin
                if (status.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            has_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            has_reg   <= has_next;
            last_reg  <= last_next;
        end
    end

    // Never overwrite a result that has not been taken.
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> status.out_free)
        else $error("result loaded while the result register is still held");

    // Sweep index never runs past the query length.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT || state_reg == S_COLRUN) |-> idx_reg <= status.qlen)
        else $error("column index beyond query length");

    // Column writes, result load and beat acceptance are mutually exclusive.
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.init_wr, cmd.cell_wr, cmd.fin}))
        else $error("conflicting datapath commands");

    // A cell update always finds the read it needs issued in the cycle before.
    a_cell_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_wr |-> $past(cmd.rd_en))
        else $error("cell update without a preceding column read");

endmodule

`default_nettype wire
